@@ design/assert_macros.svh @@
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

@@ design/fisr_pkg.sv @@
// ----------------------------------------------------------------------------
// fisr_pkg
// Constants shared by the fast inverse square root pipeline.
// ----------------------------------------------------------------------------
package fisr_pkg;

   localparam int unsigned NEWTON_STEPS_DEF = 2;

   localparam logic [31:0] MAGIC_GUESS  = 32'h5F3759DF;
   localparam logic [31:0] ONE_HALF     = 32'h3F000000;
   localparam logic [31:0] THREE_HALVES = 32'h3FC00000;
   localparam logic [31:0] CANON_NAN    = 32'h7FC00000;

   // Stage counts of the float units and of one refinement step.
   localparam int unsigned FMUL_LAT   = 3;
   localparam int unsigned FSUB_LAT   = 3;
   localparam int unsigned NEWTON_LAT = 3 * FMUL_LAT + FSUB_LAT;

endpackage

@@ design/fisr_fmul.sv @@
// ----------------------------------------------------------------------------
// fisr_fmul
// Three-stage IEEE single multiplier, round to nearest even, subnormals kept.
// ----------------------------------------------------------------------------
module fisr_fmul import fisr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [31:0] in_a,
   input  logic [31:0] in_b,
   output logic        out_valid,
   output logic [31:0] out_p
);

   function automatic logic [5:0] lzc48(input logic [47:0] v);
      logic [5:0] n;
      n = '0;
      for (int i = 0; i < 48; i++) begin
         if (v[i]) n = 6'(47 - i);
      end
      return n;
   endfunction

   // ---- stage 1: unpack, special values, mantissa product
   logic [7:0]  ea, eb;
   logic [22:0] fa, fb;
   logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sign;
   logic [23:0] ma, mb;
   logic        s1_spec_in;
   logic [31:0] s1_spec_bits_in;
   logic [47:0] s1_prod_in;
   logic [8:0]  s1_esum_in;

   assign ea = in_a[30:23];
   assign eb = in_b[30:23];
   assign fa = in_a[22:0];
   assign fb = in_b[22:0];
   assign a_nan  = (ea == 8'hFF) && (fa != '0);
   assign b_nan  = (eb == 8'hFF) && (fb != '0);
   assign a_inf  = (ea == 8'hFF) && (fa == '0);
   assign b_inf  = (eb == 8'hFF) && (fb == '0);
   assign a_zero = (ea == 8'h00) && (fa == '0);
   assign b_zero = (eb == 8'h00) && (fb == '0);
   assign sign   = in_a[31] ^ in_b[31];
   assign ma = {ea != 8'h00, fa};
   assign mb = {eb != 8'h00, fb};
   assign s1_prod_in = ma * mb;
   assign s1_esum_in = 9'((ea == 8'h00) ? 8'd1 : ea) + 9'((eb == 8'h00) ? 8'd1 : eb);

   always_comb begin
      s1_spec_in      = 1'b1;
      s1_spec_bits_in = {sign, 31'h0};
      if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
         s1_spec_bits_in = CANON_NAN;
      end else if (a_inf || b_inf) begin
         s1_spec_bits_in = {sign, 8'hFF, 23'h0};
      end else if (!(a_zero || b_zero)) begin
         s1_spec_in = 1'b0;
      end
   end

   logic        s1_valid_ff, s1_spec_ff, s1_sign_ff;
   logic [31:0] s1_spec_bits_ff;
   logic [47:0] s1_prod_ff;
   logic [8:0]  s1_esum_ff;

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else       s1_valid_ff <= in_valid;
      s1_spec_ff      <= s1_spec_in;
      s1_spec_bits_ff <= s1_spec_bits_in;
      s1_sign_ff      <= sign;
      s1_prod_ff      <= s1_prod_in;
      s1_esum_ff      <= s1_esum_in;
   end

   // ---- stage 2: leading zero count, normalising shift and exponent
   logic [5:0]         lz;
   logic signed [10:0] be;
   logic signed [10:0] sub_sh;
   logic signed [8:0]  s2_shift_in;
   logic [9:0]         s2_e0_in;

   assign lz     = lzc48(s1_prod_ff);
   assign be     = $signed({2'b0, s1_esum_ff}) - $signed({5'b0, lz}) - 11'sd126;
   assign sub_sh = $signed({2'b0, s1_esum_ff}) - 11'sd127;

   always_comb begin
      if (be >= 11'sd1) begin
         s2_shift_in = $signed({3'b0, lz});
         s2_e0_in    = 10'(be - 11'sd1);
      end else begin
         s2_shift_in = 9'(sub_sh);
         s2_e0_in    = '0;
      end
   end

   logic              s2_valid_ff, s2_spec_ff, s2_sign_ff;
   logic [31:0]       s2_spec_bits_ff;
   logic [47:0]       s2_prod_ff;
   logic signed [8:0] s2_shift_ff;
   logic [9:0]        s2_e0_ff;

   always_ff @(posedge clock) begin
      if (reset) s2_valid_ff <= 1'b0;
      else       s2_valid_ff <= s1_valid_ff;
      s2_spec_ff      <= s1_spec_ff;
      s2_spec_bits_ff <= s1_spec_bits_ff;
      s2_sign_ff      <= s1_sign_ff;
      s2_prod_ff      <= s1_prod_ff;
      s2_shift_ff     <= s2_shift_in;
      s2_e0_ff        <= s2_e0_in;
   end

   // ---- stage 3: shift, round, pack
   logic [47:0] pn;
   logic [8:0]  neg;
   logic        lost, rnd;
   logic [23:0] mant;
   logic [32:0] packed_sum;
   logic [31:0] p_in;

   assign neg = 9'(-s2_shift_ff);

   always_comb begin
      if (!s2_shift_ff[8]) begin
         pn   = s2_prod_ff << s2_shift_ff[5:0];
         lost = 1'b0;
      end else if (neg >= 9'd48) begin
         pn   = '0;
         lost = |s2_prod_ff;
      end else begin
         pn   = s2_prod_ff >> neg[5:0];
         lost = |(s2_prod_ff & ((48'd1 << neg[5:0]) - 48'd1));
      end
      mant       = pn[47:24];
      rnd        = pn[23] & ((|pn[22:0]) | lost | mant[0]);
      packed_sum = {s2_e0_ff, 23'h0} + 33'(mant) + 33'(rnd);
      if (s2_spec_ff) begin
         p_in = s2_spec_bits_ff;
      end else if (packed_sum >= 33'h07F800000) begin
         p_in = {s2_sign_ff, 8'hFF, 23'h0};
      end else begin
         p_in = {s2_sign_ff, packed_sum[30:0]};
      end
   end

   logic        out_valid_ff;
   logic [31:0] out_p_ff;

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else       out_valid_ff <= s2_valid_ff;
      out_p_ff <= p_in;
   end

   assign out_valid = out_valid_ff;
   assign out_p     = out_p_ff;

endmodule

@@ design/fisr_fsub.sv @@
// ----------------------------------------------------------------------------
// fisr_fsub
// Three-stage IEEE single subtractor a - b, round to nearest even.
// ----------------------------------------------------------------------------
module fisr_fsub import fisr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [31:0] in_a,
   input  logic [31:0] in_b,
   output logic        out_valid,
   output logic [31:0] out_d
);

   function automatic logic [4:0] lzc27(input logic [26:0] v);
      logic [4:0] n;
      n = '0;
      for (int i = 0; i < 27; i++) begin
         if (v[i]) n = 5'(26 - i);
      end
      return n;
   endfunction

   // ---- stage 1: specials, order by magnitude, align the smaller operand
   logic [31:0] nb, big, sml;
   logic        a_nan, b_nan, a_inf, b_inf, swap;
   logic [7:0]  eh, el, ehx, elx, d;
   logic [26:0] ml, ml_al;
   logic        sticky;
   logic        s1_spec_in;
   logic [31:0] s1_spec_bits_in;

   assign nb    = {~in_b[31], in_b[30:0]};
   assign a_nan = (in_a[30:23] == 8'hFF) && (in_a[22:0] != '0);
   assign b_nan = (nb[30:23] == 8'hFF) && (nb[22:0] != '0);
   assign a_inf = (in_a[30:23] == 8'hFF) && (in_a[22:0] == '0);
   assign b_inf = (nb[30:23] == 8'hFF) && (nb[22:0] == '0);
   assign swap  = nb[30:0] > in_a[30:0];
   assign big   = swap ? nb : in_a;
   assign sml   = swap ? in_a : nb;
   assign eh    = big[30:23];
   assign el    = sml[30:23];
   assign ehx   = (eh == 8'h00) ? 8'd1 : eh;
   assign elx   = (el == 8'h00) ? 8'd1 : el;
   assign d     = ehx - elx;
   assign ml    = {el != 8'h00, sml[22:0], 3'b000};

   always_comb begin
      if (d >= 8'd27) begin
         ml_al  = '0;
         sticky = |ml;
      end else begin
         ml_al  = ml >> d[4:0];
         sticky = |(ml & ((27'd1 << d[4:0]) - 27'd1));
      end
      s1_spec_in      = 1'b1;
      s1_spec_bits_in = CANON_NAN;
      if (a_nan || b_nan || (a_inf && b_inf && (in_a[31] != nb[31]))) begin
         s1_spec_bits_in = CANON_NAN;
      end else if (a_inf) begin
         s1_spec_bits_in = {in_a[31], 8'hFF, 23'h0};
      end else if (b_inf) begin
         s1_spec_bits_in = {nb[31], 8'hFF, 23'h0};
      end else begin
         s1_spec_in = 1'b0;
      end
   end

   logic        s1_valid_ff, s1_spec_ff, s1_sign_ff, s1_zsign_ff, s1_sub_ff;
   logic [31:0] s1_spec_bits_ff;
   logic [26:0] s1_mh_ff, s1_ml_ff;
   logic [7:0]  s1_exp_ff;

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else       s1_valid_ff <= in_valid;
      s1_spec_ff      <= s1_spec_in;
      s1_spec_bits_ff <= s1_spec_bits_in;
      s1_sign_ff      <= big[31];
      s1_zsign_ff     <= in_a[31] & nb[31];
      s1_sub_ff       <= in_a[31] ^ nb[31];
      s1_mh_ff        <= {eh != 8'h00, big[22:0], 3'b000};
      s1_ml_ff        <= {ml_al[26:1], ml_al[0] | sticky};
      s1_exp_ff       <= ehx;
   end

   // ---- stage 2: add or subtract magnitudes
   logic        s2_valid_ff, s2_spec_ff, s2_sign_ff, s2_zsign_ff;
   logic [31:0] s2_spec_bits_ff;
   logic [27:0] s2_sum_ff;
   logic [7:0]  s2_exp_ff;

   always_ff @(posedge clock) begin
      if (reset) s2_valid_ff <= 1'b0;
      else       s2_valid_ff <= s1_valid_ff;
      s2_spec_ff      <= s1_spec_ff;
      s2_spec_bits_ff <= s1_spec_bits_ff;
      s2_sign_ff      <= s1_sign_ff;
      s2_zsign_ff     <= s1_zsign_ff;
      s2_sum_ff       <= s1_sub_ff ? (28'(s1_mh_ff) - 28'(s1_ml_ff))
                                   : (28'(s1_mh_ff) + 28'(s1_ml_ff));
      s2_exp_ff       <= s1_exp_ff;
   end

   // ---- stage 3: normalise, round, pack
   logic [4:0]  lz, sh;
   logic [26:0] norm;
   logic [8:0]  exp_n, e0;
   logic [23:0] mant;
   logic        rnd;
   logic [32:0] packed_sum;
   logic [31:0] d_in;

   assign lz = lzc27(s2_sum_ff[26:0]);

   always_comb begin
      sh = '0;
      if (s2_sum_ff[27]) begin
         norm  = {s2_sum_ff[27:2], s2_sum_ff[1] | s2_sum_ff[0]};
         exp_n = 9'(s2_exp_ff) + 9'd1;
      end else begin
         // stop at the smallest exponent: the result is then subnormal
         if (9'(lz) > 9'(s2_exp_ff) - 9'd1) sh = 5'(s2_exp_ff - 8'd1);
         else                               sh = lz;
         norm  = s2_sum_ff[26:0] << sh;
         exp_n = 9'(s2_exp_ff) - 9'(sh);
      end
      mant       = norm[26:3];
      rnd        = norm[2] & (norm[1] | norm[0] | mant[0]);
      e0         = mant[23] ? (exp_n - 9'd1) : 9'd0;
      packed_sum = {1'b0, e0, 23'h0} + 33'(mant) + 33'(rnd);
      if (s2_spec_ff) begin
         d_in = s2_spec_bits_ff;
      end else if (s2_sum_ff == '0) begin
         d_in = {s2_zsign_ff, 31'h0};
      end else if (packed_sum >= 33'h07F800000) begin
         d_in = {s2_sign_ff, 8'hFF, 23'h0};
      end else begin
         d_in = {s2_sign_ff, packed_sum[30:0]};
      end
   end

   logic        out_valid_ff;
   logic [31:0] out_d_ff;

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else       out_valid_ff <= s2_valid_ff;
      out_d_ff <= d_in;
   end

   assign out_valid = out_valid_ff;
   assign out_d     = out_d_ff;

endmodule

@@ design/fisr_newton.sv @@
// ----------------------------------------------------------------------------
// fisr_newton
// One pipelined refinement step y * (1.5 - (x2 * y) * y).
// ----------------------------------------------------------------------------
module fisr_newton import fisr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [31:0] in_x2,
   input  logic [31:0] in_y,
   output logic        out_valid,
   output logic [31:0] out_x2,
   output logic [31:0] out_y
);

   localparam int unsigned YD = 2 * FMUL_LAT + FSUB_LAT;
   localparam int unsigned XD = NEWTON_LAT;

   logic [31:0] ydly_ff  [0:YD-1];
   logic [31:0] x2dly_ff [0:XD-1];

   // payload delay lines, kept in step with the float units
   always_ff @(posedge clock) begin
      ydly_ff[0]  <= in_y;
      x2dly_ff[0] <= in_x2;
      for (int i = 1; i < YD; i++) ydly_ff[i]  <= ydly_ff[i-1];
      for (int i = 1; i < XD; i++) x2dly_ff[i] <= x2dly_ff[i-1];
   end

   logic        a_valid, b_valid, c_valid;
   logic [31:0] a_val, b_val, c_val;

   fisr_fmul u_mul_a (
      .clock, .reset, .in_valid(in_valid), .in_a(in_x2), .in_b(in_y),
      .out_valid(a_valid), .out_p(a_val)
   );

   fisr_fmul u_mul_b (
      .clock, .reset, .in_valid(a_valid), .in_a(a_val), .in_b(ydly_ff[FMUL_LAT-1]),
      .out_valid(b_valid), .out_p(b_val)
   );

   fisr_fsub u_sub_c (
      .clock, .reset, .in_valid(b_valid), .in_a(THREE_HALVES), .in_b(b_val),
      .out_valid(c_valid), .out_d(c_val)
   );

   fisr_fmul u_mul_y (
      .clock, .reset, .in_valid(c_valid), .in_a(ydly_ff[YD-1]), .in_b(c_val),
      .out_valid(out_valid), .out_p(out_y)
   );

   assign out_x2 = x2dly_ff[XD-1];

endmodule

@@ design/fast_inverse_sqrt_float32.sv @@
// ----------------------------------------------------------------------------
// fast_inverse_sqrt_float32
// Pipelined single-precision fast reciprocal square root.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with req_x_bits; the item is taken at that edge whenever busy
//   is low. busy stays low: the pipeline takes one item every cycle.
//   Each result appears on rsp_y_bits for one cycle with rsp_valid high and
//   must be taken then; the receiver has no way to hold it off.
// Pipeline: input register, the x/2 multiplier, NEWTON_STEPS refinement
//   steps (two by default) of twelve stages each, output register.
//   Throughput: one item per cycle.
// Order: results leave in the order the items came in.
// Reset: clears every valid bit; items in flight are dropped, no result
//   follows for them, and the pipeline is ready in the next cycle.
// Any NaN result leaves as the canonical quiet NaN.
// ----------------------------------------------------------------------------
module fast_inverse_sqrt_float32 import fisr_pkg::*; #(
   parameter int unsigned NEWTON_STEPS = NEWTON_STEPS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_x_bits,
   output logic        rsp_valid,
   output logic [31:0] rsp_y_bits
);

   // never stall: every stage advances each cycle
   assign busy = 1'b0;

   // input register
   logic        in_valid_ff;
   logic [31:0] x_ff;

   always_ff @(posedge clock) begin
      if (reset) in_valid_ff <= 1'b0;
      else       in_valid_ff <= start && !busy;
      x_ff <= req_x_bits;
   end

   // starting guess from the integer view of x, held alongside the x/2 product
   logic [31:0] guess;
   logic [31:0] gdly_ff [0:FMUL_LAT-1];

   assign guess = MAGIC_GUESS - {x_ff[31], x_ff[31:1]};

   always_ff @(posedge clock) begin
      gdly_ff[0] <= guess;
      for (int i = 1; i < FMUL_LAT; i++) gdly_ff[i] <= gdly_ff[i-1];
   end

   logic        v_c  [0:NEWTON_STEPS];
   logic [31:0] x2_c [0:NEWTON_STEPS];
   logic [31:0] y_c  [0:NEWTON_STEPS];

   fisr_fmul u_half (
      .clock, .reset, .in_valid(in_valid_ff), .in_a(x_ff), .in_b(ONE_HALF),
      .out_valid(v_c[0]), .out_p(x2_c[0])
   );

   assign y_c[0] = gdly_ff[FMUL_LAT-1];

   // chain of refinement steps
   for (genvar k = 0; k < NEWTON_STEPS; k++) begin : g_step
      fisr_newton u_step (
         .clock, .reset,
         .in_valid(v_c[k]), .in_x2(x2_c[k]), .in_y(y_c[k]),
         .out_valid(v_c[k+1]), .out_x2(x2_c[k+1]), .out_y(y_c[k+1])
      );
   end

   // output register: fold every NaN to the canonical pattern
   logic        rsp_valid_ff;
   logic [31:0] rsp_y_bits_ff;
   logic [31:0] y_fin;

   assign y_fin = y_c[NEWTON_STEPS];

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= v_c[NEWTON_STEPS];
      if ((y_fin[30:23] == 8'hFF) && (y_fin[22:0] != '0)) rsp_y_bits_ff <= CANON_NAN;
      else                                               rsp_y_bits_ff <= y_fin;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_y_bits = rsp_y_bits_ff;

endmodule

@@ design/fisr_checker.sv @@
// ----------------------------------------------------------------------------
// fisr_port_checks
// Port-level checks on item count, latency and the NaN form of results.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fisr_port_checks import fisr_pkg::*; #(
   parameter int unsigned NEWTON_STEPS = NEWTON_STEPS_DEF
) (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [31:0] rsp_y_bits
);

   localparam int unsigned LATENCY = 2 + FMUL_LAT + NEWTON_STEPS * NEWTON_LAT;

   logic accepted;
   logic rsp_nan;

   assign accepted = start && !busy && !reset;
   assign rsp_nan  = rsp_valid && (rsp_y_bits[30:23] == 8'hFF) && (rsp_y_bits[22:0] != 23'h0);

   `ASSERT_IMPLIES(a_rsp_has_item, clock, reset, rsp_valid, $past(accepted, LATENCY), "result without item")
   `ASSERT_IMPLIES(a_item_has_rsp, clock, reset, $past(accepted, LATENCY), rsp_valid, "item without result")
   `ASSERT_IMPLIES(a_nan_canon, clock, reset, rsp_nan, rsp_y_bits == CANON_NAN, "non-canonical NaN")
   `ASSERT_IMPLIES(a_quiet_after_reset, clock, reset, $past(reset), !rsp_valid, "result right after reset")

endmodule

bind fast_inverse_sqrt_float32 fisr_port_checks #(.NEWTON_STEPS(NEWTON_STEPS)) u_fisr_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_y_bits(rsp_y_bits)
);
